>>> src/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants for the generational slot allocator: sizes,
// operation and status codes, slot states and the packed word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

    // field widths of the handshake words
    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int GEN_W   = 16;
    localparam int STAT_W  = 2;

    // table sizes
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

    localparam int DQ_DEPTH = 16;
    localparam int DQ_AW    = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
    localparam int DQ_CNT_W = $clog2(DQ_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_QFULL   = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_PENDING = 2'd1;
    localparam logic [1:0] SLOT_LIVE    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [INDEX_W-1:0] slot_index;
        logic [GEN_W-1:0]   generation;
    } item_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] handle_slot;
        logic [GEN_W-1:0]   handle_generation;
    } result_word_t;

    typedef struct packed {
        logic [1:0]       state;
        logic [GEN_W-1:0] gen;
    } slot_entry_t;

    typedef struct packed {
        logic [INDEX_W-1:0] slot_index;
        logic [GEN_W-1:0]   generation;
    } handle_t;

endpackage

`default_nettype wire

>>> src/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// Generic simple dual-port RAM: one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Handle allocator with generation counters and a deferred destroy queue,
// run by a small sequencer over a slot table, a free stack and the queue.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  item      in         item_valid / item_stall    gsa_pkg::item_word_t
//  result    out        result_valid / result_stall gsa_pkg::result_word_t
//
//  lookup reads the slot table; a reused allocate pops the free stack, then
//  reads the table (registered ram reads); destroy only queues its handle
//  flush applies each queued handle, then sweeps every slot handed out
//  reset clears counters and state only; slots beyond used count read fresh
//  item_stall is high while an item is in work; a stalled result holds the
//  sequencer in its last step while the next item waits
`default_nettype none

module generational_slot_allocator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire gsa_pkg::item_word_t   item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output gsa_pkg::result_word_t      result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_POP,
        ST_ALLOC_GEN,
        ST_LOOKUP,
        ST_FL_QREAD,
        ST_FL_TREAD,
        ST_FL_APPLY,
        ST_SW_READ,
        ST_SW_WRITE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [gsa_pkg::OP_W-1:0]     op_reg, op_next;
    logic [gsa_pkg::GEN_W-1:0]    gen_reg, gen_next;
    logic [gsa_pkg::SLOT_AW-1:0]  slot_reg, slot_next;
    logic [gsa_pkg::COUNT_W-1:0]  free_count_reg, free_count_next;
    logic [gsa_pkg::COUNT_W-1:0]  slots_used_reg, slots_used_next;
    logic [gsa_pkg::COUNT_W-1:0]  sweep_reg, sweep_next;
    logic [gsa_pkg::DQ_CNT_W-1:0] dq_count_reg, dq_count_next;
    logic [gsa_pkg::DQ_CNT_W-1:0] walk_reg, walk_next;
    gsa_pkg::result_word_t        res_reg, res_next;
    gsa_pkg::result_word_t        result_reg, result_next;
    logic                         result_valid_reg, result_valid_next;

    // slot table
    logic                         tbl_we;
    logic [gsa_pkg::SLOT_AW-1:0]  tbl_waddr, tbl_raddr;
    gsa_pkg::slot_entry_t         tbl_wdata, tbl_rdata;

    // free stack
    logic                         fs_we;
    logic [gsa_pkg::SLOT_AW-1:0]  fs_waddr, fs_raddr;
    logic [gsa_pkg::SLOT_AW-1:0]  fs_wdata, fs_rdata;

    // destroy queue
    logic                         dq_we;
    logic [gsa_pkg::DQ_AW-1:0]    dq_waddr, dq_raddr;
    gsa_pkg::handle_t             dq_wdata, dq_rdata;

    logic                         out_free;

    gsa_ram #(
        .WIDTH ($bits(gsa_pkg::slot_entry_t)),
        .DEPTH (gsa_pkg::SLOT_COUNT)
    ) u_slot_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    gsa_ram #(
        .WIDTH (gsa_pkg::SLOT_AW),
        .DEPTH (gsa_pkg::SLOT_COUNT)
    ) u_free_stack (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    gsa_ram #(
        .WIDTH ($bits(gsa_pkg::handle_t)),
        .DEPTH (gsa_pkg::DQ_DEPTH)
    ) u_destroy_queue (
        .clk   (clk),
        .we    (dq_we),
        .waddr (dq_waddr),
        .wdata (dq_wdata),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    assign out_free     = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        gen_next          = gen_reg;
        slot_next         = slot_reg;
        free_count_next   = free_count_reg;
        slots_used_next   = slots_used_reg;
        sweep_next        = sweep_reg;
        dq_count_next     = dq_count_reg;
        walk_next         = walk_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        tbl_we    = 1'b0;
        tbl_waddr = slot_reg;
        tbl_wdata = '{state: gsa_pkg::SLOT_FREE, gen: gen_reg};
        tbl_raddr = slot_reg;
        fs_we     = 1'b0;
        fs_waddr  = free_count_reg[gsa_pkg::SLOT_AW-1:0];
        fs_wdata  = slot_reg;
        fs_raddr  = free_count_reg[gsa_pkg::SLOT_AW-1:0];
        dq_we     = 1'b0;
        dq_waddr  = dq_count_reg[gsa_pkg::DQ_AW-1:0];
        dq_wdata  = '{slot_index: item.slot_index, generation: item.generation};
        dq_raddr  = walk_reg[gsa_pkg::DQ_AW-1:0];

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next   = item.operation;
                    gen_next  = item.generation;
                    slot_next = gsa_pkg::SLOT_AW'(item.slot_index);
                    res_next  = '{status: gsa_pkg::STATUS_OK, handle_slot: '0,
                                  handle_generation: '0};
                    case (item.operation)
                        gsa_pkg::OP_ALLOC:
                        begin
                            if (free_count_reg != '0)
                            begin
                                fs_raddr = gsa_pkg::SLOT_AW'(free_count_reg - 1'b1);
                                free_count_next = free_count_reg - 1'b1;
                                state_next = ST_ALLOC_POP;
                            end
                            else if (slots_used_reg <
                                     gsa_pkg::COUNT_W'(gsa_pkg::SLOT_COUNT))
                            begin
                                // fresh slot, generation still zero
                                tbl_we    = 1'b1;
                                tbl_waddr = slots_used_reg[gsa_pkg::SLOT_AW-1:0];
                                tbl_wdata = '{state: gsa_pkg::SLOT_PENDING, gen: '0};
                                res_next.handle_slot =
                                    gsa_pkg::INDEX_W'(slots_used_reg);
                                slots_used_next = slots_used_reg + 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                res_next.status = gsa_pkg::STATUS_FULL;
                                state_next = ST_EMIT;
                            end
                        end
                        gsa_pkg::OP_DESTROY:
                        begin
                            if (gsa_pkg::COUNT_W'(item.slot_index) >= slots_used_reg)
                            begin
                                res_next.status = gsa_pkg::STATUS_IGNORED;
                            end
                            else if (dq_count_reg ==
                                     gsa_pkg::DQ_CNT_W'(gsa_pkg::DQ_DEPTH))
                            begin
                                res_next.status = gsa_pkg::STATUS_QFULL;
                            end
                            else
                            begin
                                dq_we = 1'b1;
                                dq_count_next = dq_count_reg + 1'b1;
                            end
                            state_next = ST_EMIT;
                        end
                        gsa_pkg::OP_LOOKUP:
                        begin
                            if (gsa_pkg::COUNT_W'(item.slot_index) >= slots_used_reg)
                            begin
                                res_next.status = gsa_pkg::STATUS_IGNORED;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                tbl_raddr  = gsa_pkg::SLOT_AW'(item.slot_index);
                                state_next = ST_LOOKUP;
                            end
                        end
                        gsa_pkg::OP_FLUSH:
                        begin
                            walk_next  = '0;
                            state_next = ST_FL_QREAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ALLOC_POP:
            begin
                slot_next  = fs_rdata;
                tbl_raddr  = fs_rdata;
                state_next = ST_ALLOC_GEN;
            end

            ST_ALLOC_GEN:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = '{state: gsa_pkg::SLOT_PENDING, gen: tbl_rdata.gen};
                res_next.handle_slot       = gsa_pkg::INDEX_W'(slot_reg);
                res_next.handle_generation = tbl_rdata.gen;
                state_next = ST_EMIT;
            end

            ST_LOOKUP:
            begin
                if (tbl_rdata.state == gsa_pkg::SLOT_LIVE && tbl_rdata.gen == gen_reg)
                begin
                    res_next.status = gsa_pkg::STATUS_OK;
                end
                else
                begin
                    res_next.status = gsa_pkg::STATUS_IGNORED;
                end
                state_next = ST_EMIT;
            end

            ST_FL_QREAD:
            begin
                if (walk_reg == dq_count_reg)
                begin
                    dq_count_next = '0;
                    sweep_next    = '0;
                    state_next    = ST_SW_READ;
                end
                else
                begin
                    state_next = ST_FL_TREAD;
                end
            end

            ST_FL_TREAD:
            begin
                slot_next = gsa_pkg::SLOT_AW'(dq_rdata.slot_index);
                gen_next  = dq_rdata.generation;
                if (gsa_pkg::COUNT_W'(dq_rdata.slot_index) >= slots_used_reg)
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_FL_QREAD;
                end
                else
                begin
                    tbl_raddr  = gsa_pkg::SLOT_AW'(dq_rdata.slot_index);
                    state_next = ST_FL_APPLY;
                end
            end

            ST_FL_APPLY:
            begin
                if (tbl_rdata.gen == gen_reg &&
                    (tbl_rdata.state == gsa_pkg::SLOT_PENDING ||
                     tbl_rdata.state == gsa_pkg::SLOT_LIVE))
                begin
                    // a cancelled pending slot keeps its generation
                    tbl_we = 1'b1;
                    if (tbl_rdata.state == gsa_pkg::SLOT_LIVE)
                    begin
                        tbl_wdata = '{state: gsa_pkg::SLOT_FREE,
                                      gen: tbl_rdata.gen + 1'b1};
                    end
                    else
                    begin
                        tbl_wdata = '{state: gsa_pkg::SLOT_FREE, gen: tbl_rdata.gen};
                    end
                    if (free_count_reg < gsa_pkg::COUNT_W'(gsa_pkg::SLOT_COUNT))
                    begin
                        fs_we = 1'b1;
                        free_count_next = free_count_reg + 1'b1;
                    end
                end
                walk_next  = walk_reg + 1'b1;
                state_next = ST_FL_QREAD;
            end

            ST_SW_READ:
            begin
                if (sweep_reg == slots_used_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    tbl_raddr  = sweep_reg[gsa_pkg::SLOT_AW-1:0];
                    state_next = ST_SW_WRITE;
                end
            end

            ST_SW_WRITE:
            begin
                if (tbl_rdata.state == gsa_pkg::SLOT_PENDING)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = sweep_reg[gsa_pkg::SLOT_AW-1:0];
                    tbl_wdata = '{state: gsa_pkg::SLOT_LIVE, gen: tbl_rdata.gen};
                end
                sweep_next = sweep_reg + 1'b1;
                state_next = ST_SW_READ;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            free_count_reg   <= '0;
            slots_used_reg   <= '0;
            dq_count_reg     <= '0;
            walk_reg         <= '0;
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_count_reg   <= free_count_next;
            slots_used_reg   <= slots_used_next;
            dq_count_reg     <= dq_count_next;
            walk_reg         <= walk_next;
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        gen_reg    <= gen_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    // freed slots are distinct, so the free stack is never deeper than the used count
    assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= slots_used_reg)
        else $error("free stack deeper than used slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        dq_count_reg <= gsa_pkg::DQ_CNT_W'(gsa_pkg::DQ_DEPTH))
        else $error("destroy queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> slots_used_reg >= $past(slots_used_reg))
        else $error("used slot count went down");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && op_reg == gsa_pkg::OP_FLUSH) |-> dq_count_reg == '0)
        else $error("flush left queued handles");

endmodule

`default_nettype wire
